// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
// Clock aclk and active-low reset aresetn must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/adrcfo_pkg.sv =====
// Shared types, constants and fixed-point helpers of the first-order ADRC block.
// No dependencies.
package adrcfo_pkg;

    localparam int DATA_W            = 32;
    localparam int BW_W              = 31;
    localparam int DELAY_W           = 4;
    localparam int DRIVE_W           = 23;
    localparam int CFG_IDX_W         = 3;
    localparam int DELAY_DEPTH_DEF   = 16;
    localparam int FRAC_BITS_DEF     = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PLANT_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_BW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_BW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRK_BW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEPS = 3'd5;

    // Reset value of the sample period (about 0.01 in Q16.16)
    localparam logic [BW_W-1:0]    STEP_TIME_RST  = 31'd655;

    // Datapath micro-steps, one per controller cycle
    typedef enum logic [4:0] {
        STEP_T1, STEP_WR2, STEP_DIFF, STEP_T2, STEP_INNER,
        STEP_A, STEP_V1, STEP_B, STEP_V2,
        STEP_ERR, STEP_P1, STEP_P2, STEP_DERIV, STEP_WO2,
        STEP_P3, STEP_P4, STEP_P5, STEP_Z,
        STEP_E, STEP_P6, STEP_NUM
    } step_t;

    typedef struct packed {
        logic               load;
        logic               exec;
        step_t              step;
        logic               div_start;
        logic               finish;
    } cmd_t;

    typedef struct packed {
        logic               div_done;
        logic               out_free;
    } stat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] plant_gain;
        logic [BW_W-1:0]          ctrl_bw;
        logic [BW_W-1:0]          obs_bw;
        logic [BW_W-1:0]          trk_bw;
        logic [BW_W-1:0]          step_time;
        logic [DELAY_W-1:0]       delay_steps;
    } cfg_t;

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== src/adrc_first_order_controller_top.sv =====
// Top level of the first-order ADRC controller: ports, configuration registers, wiring.
// Depends on adrcfo_pkg, adrcfo_ctrl and adrcfo_dp.
//
//  Channel  Direction  Handshake             Payload
//  s_       in         s_tvalid / s_tready   tdata: measured_output, setpoint_raw; tuser: first
//  m_       out        m_tvalid / m_tready   tdata: drive
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample passes through the accept, 21 sequencer steps, the divider loop and one hand-off;
// the restoring divider sets most of that. A zero plant gain skips the divider loop.
// One sample is in flight at a time; s_tready is high only while the sequencer idles.
// The result waits in an output register, so a stalled m_ side holds only the hand-off.
// Reset is synchronous, active low; it restores register defaults and empties the history.
module adrc_first_order_controller_top #(
    parameter int DELAY_DEPTH = adrcfo_pkg::DELAY_DEPTH_DEF,
    parameter int FRAC_BITS   = adrcfo_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,   // [31:0] measured_output, [63:32] setpoint_raw
    input  logic                               s_tuser,   // [0] first_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // [22:0] drive, [23] zero
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [adrcfo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);
    import adrcfo_pkg::*;

    // 1.0 in the configured fixed-point format
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

    cfg_t   cfg_reg;
    cmd_t   cmd;
    stat_t  stat;
    logic [DRIVE_W-1:0] drive;

    // Configuration is always taken; writes to unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.plant_gain  <= ONE_Q[DATA_W-1:0];
            cfg_reg.ctrl_bw     <= ONE_Q[BW_W-1:0];
            cfg_reg.obs_bw      <= ONE_Q[BW_W-1:0];
            cfg_reg.trk_bw      <= ONE_Q[BW_W-1:0];
            cfg_reg.step_time   <= STEP_TIME_RST;
            cfg_reg.delay_steps <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PLANT_GAIN:  cfg_reg.plant_gain  <= cfg_data;
                REG_CTRL_BW:     cfg_reg.ctrl_bw     <= cfg_data[BW_W-1:0];
                REG_OBS_BW:      cfg_reg.obs_bw      <= cfg_data[BW_W-1:0];
                REG_TRK_BW:      cfg_reg.trk_bw      <= cfg_data[BW_W-1:0];
                REG_STEP_TIME:   cfg_reg.step_time   <= cfg_data[BW_W-1:0];
                REG_DELAY_STEPS: cfg_reg.delay_steps <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: accept a transaction, step the datapath, wait on the divider
    adrcfo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Datapath: tracking differentiator, observer, control law, drive history
    adrcfo_dp #(.DELAY_DEPTH(DELAY_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg       (cfg_reg),
        .in_meas   (s_tdata[31:0]),
        .in_setp   (s_tdata[63:32]),
        .in_first  (s_tuser),
        .drive     (drive),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = {1'b0, drive};
endmodule

// ===== src/adrcfo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module adrcfo_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/adrcfo_div.sv =====
// Restoring divider: (num << FRAC_BITS) / den, truncated, saturated to 32 bits.
// Depends on adrcfo_pkg.
module adrcfo_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [31:0]        num,
    input  logic signed [31:0]        den,
    output logic                      done,
    output logic signed [31:0]        quot
);
    import adrcfo_pkg::*;

    localparam int NB   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(NB + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic [31:0]          rem_reg, rem_next;
    logic [NB-1:0]        q_reg, q_next;
    logic [31:0]          d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic signed [31:0]   quot_reg, quot_next;
    logic [32:0]          shifted;
    logic                 ge;
    logic [31:0]          num_mag;

    assign shifted = {rem_reg, q_reg[NB-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign num_mag = num[31] ? 32'(-num) : 32'(num);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        if (start) begin
            if (den == 32'sd0) begin
                done_next = 1'b1;
                if (num > 32'sd0) begin
                    quot_next = 32'sh7FFF_FFFF;
                end else if (num < 32'sd0) begin
                    quot_next = 32'sh8000_0000;
                end else begin
                    quot_next = 32'sd0;
                end
            end else begin
                busy_next = 1'b1;
                cnt_next  = CNTW'(NB);
                rem_next  = '0;
                q_next    = {num_mag, {FRAC_BITS{1'b0}}};
                d_next    = den[31] ? 32'(-den) : 32'(den);
                neg_next  = num[31] ^ den[31];
            end
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_next = ge ? 32'(shifted - {1'b0, d_reg}) : shifted[31:0];
                q_next   = {q_reg[NB-2:0], ge};
                cnt_next = cnt_reg - CNTW'(1);
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg) begin
                    quot_next = (q_reg > NB'(64'h8000_0000)) ? 32'sh8000_0000
                                                             : 32'(-q_reg[31:0]);
                end else begin
                    quot_next = (q_reg > NB'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                             : q_reg[31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ===== src/adrcfo_dp.sv =====
// Datapath: state registers, shared Q-format multiplier, divider, drive history, output register.
// Depends on adrcfo_pkg, adrcfo_div and adrcfo_ram.
module adrcfo_dp #(
    parameter int DELAY_DEPTH = adrcfo_pkg::DELAY_DEPTH_DEF,
    parameter int FRAC_BITS   = adrcfo_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  adrcfo_pkg::cmd_t                cmd,
    output adrcfo_pkg::stat_t               stat,
    input  adrcfo_pkg::cfg_t                cfg,
    input  logic signed [31:0]              in_meas,
    input  logic signed [31:0]              in_setp,
    input  logic                            in_first,
    output logic [adrcfo_pkg::DRIVE_W-1:0]  drive,
    output logic                            out_valid,
    input  logic                            out_ready
);
    import adrcfo_pkg::*;

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CW = $clog2(DELAY_DEPTH + 1);
    localparam logic [63:0] LIM = 64'd100 << FRAC_BITS;

    logic signed [31:0] y_reg, r_reg;
    logic signed [31:0] v1_reg, v2_reg, z1_reg, z2_reg;
    logic signed [31:0] t1_reg, wr2_reg, diff_reg, t2_reg, inner_reg;
    logic signed [31:0] a_reg, sv_reg, b_reg;
    logic signed [31:0] err_reg, p1_reg, p2_reg, deriv_reg, wo2_reg;
    logic signed [31:0] p3_reg, p4_reg, p5_reg, e_reg, p6_reg, num_reg;
    logic [AW-1:0]      wp_reg;
    logic [CW-1:0]      cnt_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic               valid_reg;

    logic signed [31:0] mul_a, mul_b, qres, ud;
    logic signed [63:0] prod;
    logic [AW-1:0]      tap, rd_addr;
    logic [AW:0]        addr_sum;
    logic [DRIVE_W-1:0] rdata;
    logic               div_done;
    logic signed [31:0] div_q;
    logic [31:0]        u;

    logic signed [31:0] wr, wo, wc, dt;
    assign wr = {1'b0, cfg.trk_bw};
    assign wo = {1'b0, cfg.obs_bw};
    assign wc = {1'b0, cfg.ctrl_bw};
    assign dt = {1'b0, cfg.step_time};

    // Drive history as a ring: newest entry sits just below the write pointer
    assign tap = ({28'd0, cfg.delay_steps} >= DELAY_DEPTH) ? AW'(DELAY_DEPTH - 1)
                                                           : AW'(cfg.delay_steps);
    assign addr_sum = (AW+1)'(wp_reg) + (AW+1)'(DELAY_DEPTH - 1) - (AW+1)'(tap);
    assign rd_addr  = (addr_sum >= (AW+1)'(DELAY_DEPTH)) ?
                      AW'(addr_sum - (AW+1)'(DELAY_DEPTH)) : AW'(addr_sum);
    assign ud = (CW'(tap) < cnt_reg) ? {9'd0, rdata} : 32'sd0;

    always_comb begin
        case (cmd.step)
            STEP_T1:  begin mul_a = wr;      mul_b = v2_reg;    end
            STEP_WR2: begin mul_a = wr;      mul_b = wr;        end
            STEP_T2:  begin mul_a = wr2_reg; mul_b = diff_reg;  end
            STEP_A:   begin mul_a = dt;      mul_b = v2_reg;    end
            STEP_B:   begin mul_a = dt;      mul_b = inner_reg; end
            STEP_P1:  begin mul_a = cfg.plant_gain; mul_b = ud; end
            STEP_P2:  begin mul_a = wo;      mul_b = err_reg;   end
            STEP_WO2: begin mul_a = wo;      mul_b = wo;        end
            STEP_P3:  begin mul_a = wo2_reg; mul_b = err_reg;   end
            STEP_P4:  begin mul_a = dt;      mul_b = p3_reg;    end
            STEP_P5:  begin mul_a = dt;      mul_b = deriv_reg; end
            STEP_P6:  begin mul_a = wc;      mul_b = e_reg;     end
            default:  begin mul_a = 32'sd0;  mul_b = 32'sd0;    end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign qres = sat32(prod >>> FRAC_BITS);

    adrcfo_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den     (cfg.plant_gain),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        if (div_q < 32'sd0) begin
            u = 32'd0;
        end else if ({32'd0, div_q} > LIM) begin
            u = LIM[31:0];
        end else begin
            u = div_q;
        end
    end

    adrcfo_ram #(.WIDTH(DRIVE_W), .DEPTH(DELAY_DEPTH), .AW(AW)) u_hist (
        .aclk  (aclk),
        .we    (cmd.finish),
        .waddr (wp_reg),
        .wdata (u[DRIVE_W-1:0]),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= '0;
            v2_reg    <= '0;
            z1_reg    <= '0;
            z2_reg    <= '0;
            wp_reg    <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                y_reg <= in_meas;
                r_reg <= in_setp;
                if (in_first) begin
                    z1_reg  <= in_meas;
                    z2_reg  <= '0;
                    v1_reg  <= in_setp;
                    v2_reg  <= '0;
                    cnt_reg <= '0;
                end
            end
            if (cmd.exec) begin
                case (cmd.step)
                    STEP_T1:    t1_reg    <= qres;
                    STEP_WR2:   wr2_reg   <= qres;
                    STEP_DIFF:  diff_reg  <= sat32(sx64(v1_reg) - sx64(r_reg));
                    STEP_T2:    t2_reg    <= qres;
                    STEP_INNER: inner_reg <= sat32(64'sd0 - (sx64(t1_reg) <<< 1)
                                                   - sx64(t2_reg));
                    STEP_A:     a_reg     <= qres;
                    STEP_V1:    sv_reg    <= sat32(sx64(v1_reg) + sx64(a_reg));
                    STEP_B:     b_reg     <= qres;
                    STEP_V2: begin
                        v2_reg <= sat32(sx64(v2_reg) + sx64(b_reg));
                        v1_reg <= sv_reg;
                    end
                    STEP_ERR:   err_reg   <= sat32(sx64(y_reg) - sx64(z1_reg));
                    STEP_P1:    p1_reg    <= qres;
                    STEP_P2:    p2_reg    <= qres;
                    STEP_DERIV: deriv_reg <= sat32(sx64(z2_reg) + sx64(p1_reg)
                                                   + (sx64(p2_reg) <<< 1));
                    STEP_WO2:   wo2_reg   <= qres;
                    STEP_P3:    p3_reg    <= qres;
                    STEP_P4:    p4_reg    <= qres;
                    STEP_P5:    p5_reg    <= qres;
                    STEP_Z: begin
                        z1_reg <= sat32(sx64(z1_reg) + sx64(p5_reg));
                        z2_reg <= sat32(sx64(z2_reg) + sx64(p4_reg));
                    end
                    STEP_E:     e_reg     <= sat32(sx64(sv_reg) - sx64(z1_reg));
                    STEP_P6:    p6_reg    <= qres;
                    STEP_NUM:   num_reg   <= sat32(sx64(p6_reg) - sx64(z2_reg));
                    default: ;
                endcase
            end
            if (cmd.finish) begin
                drive_reg <= u[DRIVE_W-1:0];
                valid_reg <= 1'b1;
                wp_reg    <= (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (cnt_reg != CW'(DELAY_DEPTH)) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !valid_reg || out_ready;
    assign drive         = drive_reg;
    assign out_valid     = valid_reg;
endmodule

// ===== src/adrcfo_ctrl.sv =====
// Sequencer: walks the datapath through one sample, runs the divider, hands off the result.
// Depends on adrcfo_pkg.
module adrcfo_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    output adrcfo_pkg::cmd_t   cmd,
    input  adrcfo_pkg::stat_t  stat
);
    import adrcfo_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RUN, ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
    } state_t;

    state_t state_reg;
    step_t  step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_T1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_RUN;
                        step_reg  <= STEP_T1;
                    end
                end
                ST_RUN: begin
                    if (step_reg == STEP_NUM) begin
                        state_reg <= ST_DIV_GO;
                    end else begin
                        step_reg <= step_t'(step_reg + 5'd1);
                    end
                end
                ST_DIV_GO:   state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: if (stat.div_done) state_reg <= ST_FINISH;
                ST_FINISH:   if (stat.out_free) state_reg <= ST_IDLE;
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign cmd.load      = in_valid && in_ready;
    assign cmd.exec      = (state_reg == ST_RUN);
    assign cmd.step      = step_reg;
    assign cmd.div_start = (state_reg == ST_DIV_GO);
    assign cmd.finish    = (state_reg == ST_FINISH) && stat.out_free;
endmodule

// ===== src/adrcfo_checker.sv =====
// Port-level checker for the ADRC top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module adrcfo_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    // A stalled result holds its value
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    // Drive never leaves 0..100
    `ASSERT_CLK(a_drive_range, m_tvalid |-> m_tdata <= 24'd6553600, "drive out of range")
    // One sample at a time: after a transaction the input side closes
    `ASSERT_CLK(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input open while busy")
    // Reset empties the output register
    `ASSERT_CLK_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")
endmodule

bind adrc_first_order_controller_top adrcfo_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
